// ----- rtl/ita_pkg.sv -----
// ----------------------------------------------------------------------------
// ita_pkg: shared types and constants for the ASCII art converter
// Field widths, register indexes, gray weights, the character table and
// the control state encoding.
// ----------------------------------------------------------------------------
package ita_pkg;

	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 2;
	localparam int PIX_W     = 8;
	localparam int CHAR_W    = 7;
	localparam int SUM_W     = 18;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 2'd3;

	localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = 9'd256;
	localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = 9'd256;
	localparam logic [CFG_W-1:0] RST_OUT_WIDTH  = 9'd80;
	localparam logic [CFG_W-1:0] RST_OUT_HEIGHT = 9'd40;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_EMIT = 1'b1;

	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'd10;

	// weights sum to 1024, gray is the sum shifted down by ten
	localparam logic [SUM_W-1:0] WEIGHT_RED   = 18'd215;
	localparam logic [SUM_W-1:0] WEIGHT_GREEN = 18'd737;
	localparam logic [SUM_W-1:0] WEIGHT_BLUE  = 18'd72;

	localparam int LEVELS = 9;

	// smallest gray value reaching each level of (v*9)/255
	localparam logic [PIX_W-1:0] LEVEL_EDGE [LEVELS] = '{
		8'd29, 8'd57, 8'd85, 8'd114, 8'd142, 8'd170, 8'd199, 8'd227, 8'd255
	};

	localparam logic [CHAR_W-1:0] GLYPH [LEVELS+1] = '{
		7'h20, 7'h25, 7'h23, 7'h2A, 7'h2B, 7'h3D, 7'h2D, 7'h3A, 7'h2E, 7'h20
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_ADDR,
		ST_READ,
		ST_CHAR,
		ST_NEWLINE
	} ita_state_t;

	function automatic logic [CHAR_W-1:0] glyph_of(input logic [PIX_W-1:0] v);
		logic [3:0] level;
		level = 4'd0;
		for (int i = 0; i < LEVELS; i++) begin
			level = level + 4'(v >= LEVEL_EDGE[i]);
		end
		return GLYPH[level];
	endfunction

endpackage

// ----- rtl/ita_if.sv -----
// ----------------------------------------------------------------------------
// ita_if: request and result channels of the ASCII art converter
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface ita_req_if;
	import ita_pkg::*;

	logic             valid;
	logic             ready;
	logic             kind;
	logic [PIX_W-1:0] red;
	logic [PIX_W-1:0] green;
	logic [PIX_W-1:0] blue;

	modport source(output valid, kind, red, green, blue, input ready);
	modport sink(input valid, kind, red, green, blue, output ready);
endinterface

interface ita_res_if;
	import ita_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              last;

	modport source(output valid, character, last, input ready);
	modport sink(input valid, character, last, output ready);
endinterface

// ----- rtl/image_to_ascii_art.sv -----
// ----------------------------------------------------------------------------
// image_to_ascii_art: RGB image to ASCII art by nearest-neighbor resampling
// Gray values live in one frame store; emits scale the output position to
// the source grid and map the stored gray value to a character.
// ----------------------------------------------------------------------------
// Usage:
// - request carries kind, red, green, blue. A load (kind 0) writes one gray
//   pixel in raster order and leaves the block idle, so loads stream back
//   to back. It gives no result.
// - An emit (kind 1) gives one character on result, or at the end of an
//   output row the character with last low and then a newline with last high.
// - An emit holds request ready low until the block is idle again: the
//   divider start and wait, address, frame store read and character states,
//   plus newline at a row end; the dividers give one quotient bit per cycle.
// - The result register sits between the two sides: a stalled receiver
//   only holds the block in its character or newline state.
// - Configuration writes through cfg_we/cfg_index/cfg_wdata while idle; a
//   write takes effect from the next request on.
// - Reset clears the size registers to their defaults and the load and
//   output counters to zero. The frame store is not cleared: emit only
//   after the frame is loaded.
// ----------------------------------------------------------------------------
module image_to_ascii_art #(
	parameter int MAX_DIM = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ita_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ita_pkg::CFG_W-1:0]     cfg_wdata,
	ita_req_if.sink                       request,
	ita_res_if.source                     result
);
	import ita_pkg::*;

	localparam int EW          = $clog2(MAX_DIM + 1);
	localparam int CW          = $clog2(MAX_DIM);
	localparam int PW          = CW + EW;
	localparam int FRAME_DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW          = $clog2(FRAME_DEPTH);
	localparam int FW          = $clog2(FRAME_DEPTH + 1);
	localparam int CMP_W       = (EW > CFG_W) ? EW : CFG_W;

	ita_state_t state_q, state_d;

	logic [CFG_W-1:0] cfg_q [4];
	logic [EW-1:0]    eff   [4];
	logic [EW-1:0]    sw_eff, sh_eff, ow_eff, oh_eff;

	logic [FW-1:0]   frame_len;
	logic [AW-1:0]   load_addr_q;
	logic [AW-1:0]   wr_addr;
	logic [FW-1:0]   wr_next;
	logic [SUM_W-1:0] gray_sum;

	logic [CW-1:0] col_q, row_q;
	logic [CW-1:0] col_use, row_use;
	logic          row_end_q;
	logic [EW-1:0] row_inc;

	logic [PW-1:0] prod_x, prod_y, prod_a;
	logic [PW-1:0] prod_x_s1, prod_y_s1;
	logic          div_start, qx_done, qy_done;
	logic [CW-1:0] sx, sy;
	logic [AW-1:0] rd_addr_s3;
	logic [PIX_W-1:0] rdata_q;

	logic [PIX_W-1:0] gray_mem [FRAME_DEPTH];

	logic              req_ready;
	logic              load_fire, emit_fire;
	logic              out_free, out_load, out_last_d;
	logic [CHAR_W-1:0] out_char_d;
	logic              out_valid_q, out_last_q;
	logic [CHAR_W-1:0] out_char_q;

	// configuration registers and their clamped sizes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_SRC_WIDTH]  <= RST_SRC_WIDTH;
			cfg_q[REG_SRC_HEIGHT] <= RST_SRC_HEIGHT;
			cfg_q[REG_OUT_WIDTH]  <= RST_OUT_WIDTH;
			cfg_q[REG_OUT_HEIGHT] <= RST_OUT_HEIGHT;
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_wdata;
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (cfg_q[i] == '0) begin
				eff[i] = EW'(1);
			end else if (CMP_W'(cfg_q[i]) > CMP_W'(MAX_DIM)) begin
				eff[i] = EW'(MAX_DIM);
			end else begin
				eff[i] = EW'(cfg_q[i]);
			end
		end
	end

	assign sw_eff = eff[REG_SRC_WIDTH];
	assign sh_eff = eff[REG_SRC_HEIGHT];
	assign ow_eff = eff[REG_OUT_WIDTH];
	assign oh_eff = eff[REG_OUT_HEIGHT];

	assign frame_len = FW'(sw_eff) * FW'(sh_eff);

	assign load_fire = request.valid && req_ready && (request.kind == KIND_LOAD);
	assign emit_fire = request.valid && req_ready && (request.kind == KIND_EMIT);

	// load path: gray conversion and frame store write in the accept cycle
	assign gray_sum = WEIGHT_RED * SUM_W'(request.red) + WEIGHT_GREEN * SUM_W'(request.green)
		+ WEIGHT_BLUE * SUM_W'(request.blue);
	assign wr_addr  = (FW'(load_addr_q) >= frame_len) ? '0 : load_addr_q;
	assign wr_next  = FW'(wr_addr) + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_addr_q <= '0;
		end else if (load_fire) begin
			load_addr_q <= (wr_next >= frame_len) ? '0 : wr_next[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load_fire) begin
			gray_mem[wr_addr] <= gray_sum[SUM_W-1:SUM_W-PIX_W];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rdata_q <= gray_mem[rd_addr_s3];
		end
	end

	// emit path: restart counters beyond a changed size, then scale
	assign col_use = (EW'(col_q) >= ow_eff) ? '0 : col_q;
	assign row_use = (EW'(row_q) >= oh_eff) ? '0 : row_q;
	assign prod_x  = PW'(col_use) * PW'(sw_eff);
	assign prod_y  = PW'(row_use) * PW'(sh_eff);
	assign prod_a  = PW'(sy) * PW'(sw_eff) + PW'(sx);
	assign row_inc = EW'(row_q) + 1'b1;

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			prod_x_s1 <= prod_x;
			prod_y_s1 <= prod_y;
		end
		if (state_q == ST_ADDR) begin
			rd_addr_s3 <= prod_a[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			row_end_q <= 1'b0;
		end else if (emit_fire) begin
			col_q     <= col_use;
			row_q     <= row_use;
			row_end_q <= (EW'(col_use) + 1'b1) >= ow_eff;
		end else if (out_load && state_q == ST_CHAR) begin
			if (row_end_q) begin
				col_q <= '0;
				row_q <= (row_inc >= oh_eff) ? '0 : row_inc[CW-1:0];
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	ita_div #(.QW(CW), .EW(EW)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_x_s1),
		.divisor  (ow_eff),
		.done     (qx_done),
		.quotient (sx)
	);

	ita_div #(.QW(CW), .EW(EW)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_y_s1),
		.divisor  (oh_eff),
		.done     (qy_done),
		.quotient (sy)
	);

	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		div_start  = 1'b0;
		out_load   = 1'b0;
		out_char_d = CHAR_NEWLINE;
		out_last_d = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (request.valid && request.kind == KIND_EMIT) begin
					state_d = ST_DIV_START;
				end
			end
			ST_DIV_START: begin
				div_start = 1'b1;
				state_d   = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				// both dividers run in lockstep
				if (qx_done && qy_done) begin
					state_d = ST_ADDR;
				end
			end
			ST_ADDR: begin
				state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_CHAR;
			end
			ST_CHAR: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_char_d = glyph_of(rdata_q);
					out_last_d = !row_end_q;
					state_d    = row_end_q ? ST_NEWLINE : ST_IDLE;
				end
			end
			ST_NEWLINE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// result register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_char_q <= out_char_d;
			out_last_q <= out_last_d;
		end
	end

	assign request.ready    = req_ready;
	assign result.valid     = out_valid_q;
	assign result.character = out_char_q;
	assign result.last      = out_last_q;

	a_emit_blocks_request: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |=> !request.ready)
		else $error("request taken while an emit is in progress");

	a_newline_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.character == CHAR_NEWLINE) |-> result.last)
		else $error("newline result without last");

	a_newline_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.ready && !result.last) |=>
			(result.valid && result.character == CHAR_NEWLINE))
		else $error("row end character not followed by newline");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		qx_done |-> (state_q == ST_DIV_WAIT))
		else $error("divider finished outside the wait state");

endmodule

// ----- rtl/ita_div.sv -----
// ----------------------------------------------------------------------------
// ita_div: radix-2 restoring divider
// Produces QW quotient bits, one per cycle. The caller guarantees that the
// quotient fits QW bits, so the upper dividend part already lies below the
// divisor and only the low bits need stepping.
// ----------------------------------------------------------------------------
module ita_div #(
	parameter int QW = 8,
	parameter int EW = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [QW+EW-1:0] dividend,
	input  logic [EW-1:0]    divisor,
	output logic             done,
	output logic [QW-1:0]    quotient
);
	localparam int CNT_W = $clog2(QW);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [EW-1:0]    rem_q;
	logic [EW-1:0]    divisor_q;
	logic [QW-1:0]    low_q;
	logic [EW:0]      trial;
	logic             fits;

	assign trial = {rem_q, low_q[QW-1]};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= dividend[QW+EW-1:QW];
			low_q     <= dividend[QW-1:0];
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? EW'(trial - {1'b0, divisor_q}) : trial[EW-1:0];
			low_q <= {low_q[QW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = low_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < divisor_q)
		else $error("partial remainder reached the divisor");

	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the image to ASCII art converter
// Walks a short table of directed requests and register writes, then random
// phases of loads and emits, each phase free to set new frame and output sizes.
// An in-bench model of the frame store and output raster predicts characters
// and newlines not typed in directed steps; all checked in order, field by field.
// ----------------------------------------------------------------------------
module testbench;
	import ita_pkg::*;

	localparam int          FRAME_DIM      = 256;
	localparam int unsigned FRAME_DEPTH    = FRAME_DIM * FRAME_DIM;
	localparam int          SETTLE_CYCLES  = 24;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          ITEM_TARGET    = 1250;

	localparam logic [7:0] RAMP [10] = '{" ", "%", "#", "*", "+", "=", "-", ":", ".", " "};

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} glyph_t;

	typedef enum logic { STEP_WRITE, STEP_SEND } step_op_t;

	typedef struct packed {
		step_op_t             op;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_W-1:0]     wdata;
		logic                 kind;
		logic [PIX_W-1:0]     red;
		logic [PIX_W-1:0]     green;
		logic [PIX_W-1:0]     blue;
		logic [1:0]           typed_n;
		logic [CHAR_W-1:0]    typed_char;
	} step_t;

	// typed_n: 0 = take the prediction, 1 = one character, 2 = character + newline
	localparam step_t DIRECTED [27] = '{
		'{STEP_SEND,  REG_SRC_WIDTH,  9'd0,   KIND_LOAD, 8'd255, 8'd255, 8'd255, 2'd0, 7'h00},
		'{STEP_SEND,  REG_SRC_WIDTH,  9'd0,   KIND_EMIT, 8'd0,   8'd0,   8'd0,   2'd1, 7'h20},
		'{STEP_WRITE, REG_SRC_WIDTH,  9'd0,   KIND_LOAD, 8'd0,   8'd0,   8'd0,   2'd0, 7'h00},
		'{STEP_WRITE, REG_SRC_HEIGHT, 9'd0,   KIND_LOAD, 8'd0,   8'd0,   8'd0,   2'd0, 7'h00},
		'{STEP_WRITE, REG_OUT_WIDTH,  9'd0,   KIND_LOAD, 8'd0,   8'd0,   8'd0,   2'd0, 7'h00},
		'{STEP_WRITE, REG_OUT_HEIGHT, 9'd0,   KIND_LOAD, 8'd0,   8'd0,   8'd0,   2'd0, 7'h00},
		'{STEP_SEND,  REG_SRC_WIDTH,  9'd0,   KIND_LOAD, 8'd0,   8'd0,   8'd0,   2'd0, 7'h00},
		'{STEP_SEND,  REG_SRC_WIDTH,  9'd0,   KIND_EMIT, 8'd255, 8'd255, 8'd255, 2'd2, 7'h20},
		'{STEP_SEND,  REG_SRC_WIDTH,  9'd0,   KIND_LOAD, 8'd29,  8'd29,  8'd29,  2'd0, 7'h00},
		'{STEP_SEND,  REG_SRC_WIDTH,  9'd0,   KIND_EMIT, 8'd0,   8'd0,   8'd0,   2'd0, 7'h00},
		'{STEP_SEND,  REG_SRC_WIDTH,  9'd0,   KIND_LOAD, 8'd254, 8'd254, 8'd254, 2'd0, 7'h00},
		'{STEP_SEND,  REG_SRC_WIDTH,  9'd0,   KIND_EMIT, 8'd0,   8'd0,   8'd0,   2'd0, 7'h00},
		'{STEP_SEND,  REG_SRC_WIDTH,  9'd0,   KIND_LOAD, 8'd255, 8'd0,   8'd0,   2'd0, 7'h00},
		'{STEP_SEND,  REG_SRC_WIDTH,  9'd0,   KIND_EMIT, 8'd0,   8'd0,   8'd0,   2'd0, 7'h00},
		'{STEP_SEND,  REG_SRC_WIDTH,  9'd0,   KIND_LOAD, 8'd0,   8'd255, 8'd0,   2'd0, 7'h00},
		'{STEP_SEND,  REG_SRC_WIDTH,  9'd0,   KIND_EMIT, 8'd0,   8'd0,   8'd0,   2'd0, 7'h00},
		'{STEP_SEND,  REG_SRC_WIDTH,  9'd0,   KIND_LOAD, 8'd0,   8'd0,   8'd255, 2'd0, 7'h00},
		'{STEP_SEND,  REG_SRC_WIDTH,  9'd0,   KIND_EMIT, 8'd0,   8'd0,   8'd0,   2'd0, 7'h00},
		'{STEP_WRITE, REG_OUT_WIDTH,  9'd300, KIND_LOAD, 8'd0,   8'd0,   8'd0,   2'd0, 7'h00},
		'{STEP_SEND,  REG_SRC_WIDTH,  9'd0,   KIND_EMIT, 8'd0,   8'd0,   8'd0,   2'd0, 7'h00},
		'{STEP_SEND,  REG_SRC_WIDTH,  9'd0,   KIND_EMIT, 8'd0,   8'd0,   8'd0,   2'd0, 7'h00},
		'{STEP_SEND,  REG_SRC_WIDTH,  9'd0,   KIND_EMIT, 8'd0,   8'd0,   8'd0,   2'd0, 7'h00},
		'{STEP_WRITE, REG_OUT_WIDTH,  9'd1,   KIND_LOAD, 8'd0,   8'd0,   8'd0,   2'd0, 7'h00},
		'{STEP_SEND,  REG_SRC_WIDTH,  9'd0,   KIND_EMIT, 8'd0,   8'd0,   8'd0,   2'd0, 7'h00},
		'{STEP_WRITE, REG_OUT_HEIGHT, 9'd511, KIND_LOAD, 8'd0,   8'd0,   8'd0,   2'd0, 7'h00},
		'{STEP_SEND,  REG_SRC_WIDTH,  9'd0,   KIND_EMIT, 8'd0,   8'd0,   8'd0,   2'd0, 7'h00},
		'{STEP_SEND,  REG_SRC_WIDTH,  9'd0,   KIND_EMIT, 8'd0,   8'd0,   8'd0,   2'd0, 7'h00}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	ita_req_if req_ch();
	ita_res_if res_ch();

	image_to_ascii_art u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.request  (req_ch),
		.result   (res_ch)
	);

	// shadow of the converter
	logic [CFG_W-1:0] dims [4] = '{RST_SRC_WIDTH, RST_SRC_HEIGHT, RST_OUT_WIDTH, RST_OUT_HEIGHT};
	logic [PIX_W-1:0] luma_mem [FRAME_DEPTH];
	bit               loaded [FRAME_DEPTH];
	int unsigned      fill_ptr = 0;
	int unsigned      char_x = 0;
	int unsigned      char_y = 0;

	glyph_t pending_glyphs [$];
	int     requests_sent = 0;
	int     mismatches = 0;
	int     quiet_cycles = 0;
	bit     sender_calm = 0;
	bit     long_hold_wanted = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned span(input logic [CFG_W-1:0] raw);
		if (raw == '0) return 1;
		if (raw > FRAME_DIM) return FRAME_DIM;
		return raw;
	endfunction

	// frame-store address read by the next emit
	function automatic int unsigned emit_address();
		int unsigned sw, sh, ow, oh, x, y;
		sw = span(dims[REG_SRC_WIDTH]);
		sh = span(dims[REG_SRC_HEIGHT]);
		ow = span(dims[REG_OUT_WIDTH]);
		oh = span(dims[REG_OUT_HEIGHT]);
		x = (char_x >= ow) ? 0 : char_x;
		y = (char_y >= oh) ? 0 : char_y;
		return ((y * sh / oh) * sw + x * sw / ow) % FRAME_DEPTH;
	endfunction

	function automatic void convert_request(input logic kind, input logic [PIX_W-1:0] red,
			input logic [PIX_W-1:0] green, input logic [PIX_W-1:0] blue,
			output int count, output glyph_t first, output glyph_t second);
		int unsigned frame, luma, level, ow, oh;
		ow = span(dims[REG_OUT_WIDTH]);
		oh = span(dims[REG_OUT_HEIGHT]);
		first = '0;
		second = '{character: CHAR_NEWLINE, last: 1'b1};
		count = 0;
		if (kind == KIND_LOAD) begin
			frame = span(dims[REG_SRC_WIDTH]) * span(dims[REG_SRC_HEIGHT]);
			luma = (215 * int'(red) + 737 * int'(green) + 72 * int'(blue)) >> 10;
			if (fill_ptr >= frame) fill_ptr = 0;
			luma_mem[fill_ptr] = PIX_W'(luma);
			loaded[fill_ptr] = 1'b1;
			fill_ptr++;
			if (fill_ptr >= frame) fill_ptr = 0;
		end else begin
			// restart counters left beyond a shrunk raster
			if (char_x >= ow) char_x = 0;
			if (char_y >= oh) char_y = 0;
			level = int'(luma_mem[emit_address()]) * 9 / 255;
			first.character = CHAR_W'(RAMP[level]);
			if (char_x + 1 >= ow) begin
				first.last = 1'b0;
				count = 2;
				char_x = 0;
				char_y++;
				if (char_y >= oh) char_y = 0;
			end else begin
				first.last = 1'b1;
				count = 1;
				char_x++;
			end
		end
	endfunction

	task automatic send_request(input logic kind, input logic [PIX_W-1:0] red,
			input logic [PIX_W-1:0] green, input logic [PIX_W-1:0] blue,
			input int typed_n, input logic [CHAR_W-1:0] typed_char);
		glyph_t first, second;
		int     count;
		req_ch.valid <= 1'b1;
		req_ch.kind  <= kind;
		req_ch.red   <= red;
		req_ch.green <= green;
		req_ch.blue  <= blue;
		do @(posedge clk); while (!req_ch.ready);
		convert_request(kind, red, green, blue, count, first, second);
		if (typed_n != 0) begin
			count = typed_n;
			first = '{character: typed_char, last: (typed_n == 1)};
			second = '{character: CHAR_NEWLINE, last: 1'b1};
		end
		if (count > 0) pending_glyphs.push_back(first);
		if (count > 1) pending_glyphs.push_back(second);
		requests_sent++;
	endtask

	task automatic pace_sender();
		int gap, p;
		gap = 0;
		if (!sender_calm) begin
			p = $urandom_range(0, 99);
			if (p >= 93) gap = $urandom_range(8, 40);
			else if (p >= 55) gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drop valid, drain all results, let the block go idle
	task automatic settle_block();
		req_ch.valid <= 1'b0;
		while (pending_glyphs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
		dims[index] = value;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_load();
		logic [PIX_W-1:0] r, g, b;
		int               p;
		p = $urandom_range(0, 9);
		if (p < 6) begin
			{r, g, b} = 24'($urandom);
		end else if (p < 8) begin
			r = PIX_W'($urandom);
			g = r;
			b = r;
		end else begin
			r = {PIX_W{1'($urandom_range(0, 1))}};
			g = {PIX_W{1'($urandom_range(0, 1))}};
			b = {PIX_W{1'($urandom_range(0, 1))}};
		end
		send_request(KIND_LOAD, r, g, b, 0, '0);
		pace_sender();
	endtask

	// never read an entry that was not loaded: load instead
	task automatic send_emit();
		if (loaded[emit_address()]) begin
			send_request(KIND_EMIT, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), 0, '0);
			pace_sender();
		end else begin
			send_load();
		end
	endtask

	function automatic logic [CFG_W-1:0] pick_src_size();
		if ($urandom_range(0, 19) == 0) return '0;
		return CFG_W'($urandom_range(1, 6));
	endfunction

	function automatic logic [CFG_W-1:0] pick_out_size();
		int p;
		p = $urandom_range(0, 19);
		if (p == 0) return '0;
		if (p == 1) return CFG_W'($urandom_range(257, 511));
		if (p == 2) return CFG_W'(FRAME_DIM);
		return CFG_W'($urandom_range(1, 10));
	endfunction

	task automatic run_phase(input int phase_no);
		int unsigned frame, raster, emits;
		settle_block();
		if (phase_no == 1) begin
			write_reg(REG_SRC_WIDTH, 9'd511);
			write_reg(REG_SRC_HEIGHT, 9'd0);
			write_reg(REG_OUT_WIDTH, 9'd256);
			write_reg(REG_OUT_HEIGHT, 9'd1);
		end else if (phase_no == 4) begin
			write_reg(REG_SRC_WIDTH, 9'd1);
			write_reg(REG_SRC_HEIGHT, 9'd256);
			write_reg(REG_OUT_WIDTH, 9'd0);
			write_reg(REG_OUT_HEIGHT, 9'd511);
		end else begin
			if (phase_no == 0 || $urandom_range(0, 9) < 7) write_reg(REG_SRC_WIDTH, pick_src_size());
			if (phase_no == 0 || $urandom_range(0, 9) < 7) write_reg(REG_SRC_HEIGHT, pick_src_size());
			if (phase_no == 0 || $urandom_range(0, 9) < 7) write_reg(REG_OUT_WIDTH, pick_out_size());
			if (phase_no == 0 || $urandom_range(0, 9) < 7) write_reg(REG_OUT_HEIGHT, pick_out_size());
		end
		sender_calm = ($urandom_range(0, 3) == 0);
		frame = span(dims[REG_SRC_WIDTH]) * span(dims[REG_SRC_HEIGHT]);
		raster = span(dims[REG_OUT_WIDTH]) * span(dims[REG_OUT_HEIGHT]);

		if (phase_no == 1 || phase_no == 4 || $urandom_range(0, 9) < 8) begin
			repeat (frame) send_load();
			if (phase_no == 1) begin
				emits = raster + $urandom_range(1, 4);
				long_hold_wanted = 1'b1;
			end else if (phase_no == 4) begin
				emits = $urandom_range(20, 40);
			end else begin
				emits = $urandom_range(1, 2 * raster + 2);
				if (emits > 60) emits = $urandom_range(20, 60);
			end
			repeat (emits) begin
				if ($urandom_range(0, 9) == 0) send_load();
				send_emit();
			end
		end else begin
			// loose mix: loads wrap mid-frame, emits land wherever the raster is
			repeat ($urandom_range(4, 40)) begin
				if ($urandom_range(0, 1) == 0) send_load();
				else send_emit();
			end
		end
	endtask

	// result side: random ready, one long hold-off while emits are queued
	initial begin
		int stall, calm, p;
		bit long_done;
		stall = 0;
		calm = 0;
		long_done = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_wanted && !long_done) begin
				long_done = 1;
				stall = $urandom_range(220, 300);
			end else if (stall == 0 && calm > 0) begin
				calm--;
			end else if (stall == 0) begin
				p = $urandom_range(0, 999);
				if (p < 30) calm = $urandom_range(50, 200);
				else if (p < 200) stall = $urandom_range(1, 3);
				else if (p < 220) stall = $urandom_range(10, 40);
				else if (p < 222) stall = $urandom_range(80, 150);
			end
			res_ch.ready <= (stall == 0);
			if (stall > 0) stall--;
		end
	end

	always @(posedge clk) begin
		glyph_t want;
		if (res_ch.valid && res_ch.ready) begin
			if (pending_glyphs.size() == 0) begin
				mismatches++;
				$display("%0t: result with none pending: character %0d last %0b", $time,
					res_ch.character, res_ch.last);
			end else begin
				want = pending_glyphs.pop_front();
				if (res_ch.character !== want.character) begin
					mismatches++;
					$display("%0t: character expected %0d got %0d", $time, want.character,
						res_ch.character);
				end
				if (res_ch.last !== want.last) begin
					mismatches++;
					$display("%0t: last expected %0b got %0b", $time, want.last, res_ch.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		int phase_no;
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= '0;
		cfg_wdata    <= '0;
		req_ch.valid <= 1'b0;
		req_ch.kind  <= KIND_LOAD;
		req_ch.red   <= '0;
		req_ch.green <= '0;
		req_ch.blue  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].op == STEP_WRITE) begin
				settle_block();
				write_reg(DIRECTED[i].index, DIRECTED[i].wdata);
			end else begin
				send_request(DIRECTED[i].kind, DIRECTED[i].red, DIRECTED[i].green,
					DIRECTED[i].blue, DIRECTED[i].typed_n, DIRECTED[i].typed_char);
				pace_sender();
			end
		end

		phase_no = 0;
		while (requests_sent < ITEM_TARGET) begin
			run_phase(phase_no);
			phase_no++;
		end
		settle_block();

		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
